// File: hdl/rdh_pkg.sv
// ----------------------------------------------------------------------------
// rdh_pkg
// Shared types and constants of the radial density histogram.
// ----------------------------------------------------------------------------
package rdh_pkg;

   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Square root operand and result widths.
   localparam int ROOT_IN_W  = 48;
   localparam int ROOT_OUT_W = 24;

   // Wide enough for any bin count up to 256.
   localparam int BIN_CNT_W = 9;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUM_RADIAL  = 3'd0,
      CSR_RAD_SCALE   = 3'd1,
      CSR_NUM_DENSITY = 3'd2,
      CSR_DENS_LOW    = 3'd3,
      CSR_DENS_HIGH   = 3'd4
   } csr_index_type;

   localparam logic REQ_ACCUM = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef struct packed {
      logic busy;
      logic ovf;
   } div_status_type;

endpackage

// File: hdl/rdh_isqrt.sv
// ----------------------------------------------------------------------------
// rdh_isqrt
// Bit-serial integer square root, two operand bits per cycle.
// ----------------------------------------------------------------------------
module rdh_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rdh_pkg::ROOT_IN_W-1:0]  operand,
   output logic                           busy,
   output logic [rdh_pkg::ROOT_OUT_W-1:0] root
);
   import rdh_pkg::*;

   localparam int RW = ROOT_OUT_W + 2;
   localparam int CW = $clog2(ROOT_OUT_W + 1);

   logic [ROOT_IN_W-1:0]  shift_ff;
   logic [RW-1:0]         rem_ff;
   logic [ROOT_OUT_W-1:0] root_ff;
   logic [CW-1:0]         cnt_ff;
   logic [RW-1:0]         rem_try;
   logic [RW-1:0]         trial;

   assign rem_try = {rem_ff[RW-3:0], shift_ff[ROOT_IN_W-1 -: 2]};
   assign trial   = {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CW'(ROOT_OUT_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= operand;
         rem_ff   <= '0;
         root_ff  <= '0;
      end else if (cnt_ff != '0) begin
         shift_ff <= {shift_ff[ROOT_IN_W-3:0], 2'b00};
         if (rem_try >= trial) begin
            rem_ff  <= rem_try - trial;
            root_ff <= {root_ff[ROOT_OUT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_try;
            root_ff <= {root_ff[ROOT_OUT_W-2:0], 1'b0};
         end
      end
   end

   assign busy = (cnt_ff != '0);
   assign root = root_ff;

endmodule

// File: hdl/rdh_sdiv.sv
// ----------------------------------------------------------------------------
// rdh_sdiv
// Bit-serial restoring divider with a bounded quotient of QW bits.
// ----------------------------------------------------------------------------
module rdh_sdiv #(
   parameter int NW = 40,
   parameter int DW = 32,
   parameter int QW = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NW-1:0]                 num,
   input  logic [DW-1:0]                 den,
   output rdh_pkg::div_status_type       status,
   output logic [QW-1:0]                 quo
);
   import rdh_pkg::*;

   localparam int EW = (NW > DW + QW) ? NW : DW + QW;
   localparam int CW = $clog2(QW + 1);

   logic [EW-1:0] rem_ff;
   logic [EW-1:0] dsh_ff;
   logic [QW-1:0] quo_ff;
   logic [CW-1:0] cnt_ff;
   logic          ovf_ff;
   logic          ge;

   assign ge = (rem_ff >= dsh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CW'(QW);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= EW'(num);
         dsh_ff <= EW'(den) << (QW - 1);
         ovf_ff <= (EW'(num) >= (EW'(den) << QW));
         quo_ff <= '0;
      end else if (cnt_ff != '0) begin
         if (ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         quo_ff <= QW'({quo_ff, ge});
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign status.busy = (cnt_ff != '0);
   assign status.ovf  = ovf_ff;
   assign quo         = quo_ff;

endmodule

// File: hdl/radial_density_histogram.sv
// ----------------------------------------------------------------------------
// radial_density_histogram
// Two-dimensional histogram of grid cells by radial distance and density.
// ----------------------------------------------------------------------------
// After reset the block clears its MAX_RADIAL_BINS*MAX_DENSITY_BINS count
// memory one entry per cycle (4096 entries at the default size) and takes no
// word until that pass ends. An accumulate word passes through a squaring
// stage, a product stage that starts the 24-step bit-serial square root and
// the density division beside it, a bit-serial radial division of
// log2(MAX_RADIAL_BINS) steps once both are done, then one memory read and
// one write back. A read word goes straight to the memory read, then clears
// the entry that it read when that entry is in range. Results are held in an
// output register, so a new word is taken while the previous result waits.
module radial_density_histogram #(
   parameter int MAX_RADIAL_BINS  = 64,
   parameter int MAX_DENSITY_BINS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // offset_x, offset_y, offset_z, void_radius, cell_density,
   // read_radial, read_density
   input  logic [rdh_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  logic [0:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // counted, radial_bin, density_bin, bin_count
   output logic [rdh_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rdh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rdh_pkg::CSR_DATA_W-1:0]   csr_data
);
   import rdh_pkg::*;

   localparam int QR    = (MAX_RADIAL_BINS > 1) ? $clog2(MAX_RADIAL_BINS) : 1;
   localparam int QD    = (MAX_DENSITY_BINS > 1) ? $clog2(MAX_DENSITY_BINS) : 1;
   localparam int DEPTH = MAX_RADIAL_BINS * MAX_DENSITY_BINS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_SQ    = 8'b0000_0100,
      S_PROD  = 8'b0000_1000,
      S_ROOT  = 8'b0001_0000,
      S_RDIV  = 8'b0010_0000,
      S_LOOK  = 8'b0100_0000,
      S_FIN   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Configuration.
   logic [6:0]         nrb_ff;
   logic [4:0]         rscale_ff;
   logic [6:0]         ndb_ff;
   logic signed [31:0] dlow_ff;
   logic signed [31:0] dhigh_ff;

   // Captured word.
   logic               type_ff;
   logic signed [8:0]  x_ff, y_ff, z_ff;
   logic [15:0]        rad_ff;
   logic signed [31:0] dens_ff;
   logic [5:0]         rr_ff, rd_ff;

   // Datapath.
   logic [16:0]        xsq_ff, ysq_ff, zsq_ff;
   logic [13:0]        nb2_ff;
   logic [20:0]        k_ff;
   logic [32:0]        diff_ff, span_ff;
   logic               dens_bad_ff;
   logic [31:0]        p;
   logic [39:0]        numd;
   logic [17:0]        d2;

   logic               root_start, dden_start, rdiv_start;
   logic               root_busy;
   logic [ROOT_OUT_W-1:0] root;
   div_status_type     dden_st, rdiv_st;
   logic [QD-1:0]      jbin;
   logic [QR-1:0]      ibin;

   logic [BIN_CNT_W-1:0] nr, nd;
   logic               hit;
   logic               in_range;
   logic [AW-1:0]      addr_in;

   logic               hit_ff, in_range_ff;
   logic [AW-1:0]      addr_ff;
   logic [5:0]         rbin_ff, dbin_ff;
   logic [31:0]        rdata_ff;
   logic [AW-1:0]      clr_ff;
   logic [31:0]        hist [DEPTH];

   logic               out_free;
   logic               req_accept;
   logic               rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         nrb_ff    <= 7'd10;
         rscale_ff <= 5'd2;
         ndb_ff    <= 7'd10;
         dlow_ff   <= -32'sd65536;
         dhigh_ff  <= 32'sd131072;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NUM_RADIAL:  nrb_ff    <= csr_data[6:0];
            CSR_RAD_SCALE:   rscale_ff <= csr_data[4:0];
            CSR_NUM_DENSITY: ndb_ff    <= csr_data[6:0];
            CSR_DENS_LOW:    dlow_ff   <= csr_data;
            CSR_DENS_HIGH:   dhigh_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------ FSM
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (req_accept) begin
               state_in = (req_tuser[0] == REQ_READ) ? S_LOOK : S_SQ;
            end
         end
         S_SQ:   state_in = S_PROD;
         S_PROD: state_in = S_ROOT;
         S_ROOT: if (!root_busy && !dden_st.busy) state_in = S_RDIV;
         S_RDIV: if (!rdiv_st.busy) state_in = S_LOOK;
         S_LOOK: state_in = S_FIN;
         S_FIN:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   // -------------------------------------------------------------- capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         type_ff <= req_tuser[0];
         x_ff    <= req_tdata[8:0];
         y_ff    <= req_tdata[17:9];
         z_ff    <= req_tdata[26:18];
         rad_ff  <= req_tdata[42:27];
         dens_ff <= req_tdata[74:43];
         rr_ff   <= req_tdata[80:75];
         rd_ff   <= req_tdata[86:81];
      end
   end

   // Squares, scale product and density offsets.
   always_ff @(posedge clock) begin
      if (state_ff == S_SQ) begin
         xsq_ff      <= 17'(18'(x_ff) * 18'(x_ff));
         ysq_ff      <= 17'(18'(y_ff) * 18'(y_ff));
         zsq_ff      <= 17'(18'(z_ff) * 18'(z_ff));
         nb2_ff      <= 14'(nrb_ff) * 14'(nrb_ff);
         k_ff        <= 21'(rad_ff) * 21'(rscale_ff);
         diff_ff     <= 33'(dens_ff) - 33'(dlow_ff);
         span_ff     <= 33'(dhigh_ff) - 33'(dlow_ff);
      end
   end

   assign d2 = 18'(xsq_ff) + 18'(ysq_ff) + 18'(zsq_ff);

   // The serial units load these products directly when they start.
   assign p    = 32'(d2) * 32'(nb2_ff);
   assign numd = 40'(diff_ff[31:0]) * 40'(ndb_ff);

   always_ff @(posedge clock) begin
      if (state_ff == S_PROD) begin
         // Below the lower bound, or an empty or inverted span.
         dens_bad_ff <= diff_ff[32] || span_ff[32] || (span_ff == '0);
      end
   end

   assign root_start = (state_ff == S_PROD);
   assign dden_start = (state_ff == S_PROD);
   assign rdiv_start = (state_ff == S_ROOT) && !root_busy && !dden_st.busy;

   rdh_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand ({p, 16'h0000}),
      .busy    (root_busy),
      .root    (root)
   );

   rdh_sdiv #(.NW(40), .DW(32), .QW(QD)) u_ddiv (
      .clock  (clock),
      .reset  (reset),
      .start  (dden_start),
      .num    (numd),
      .den    (span_ff[31:0]),
      .status (dden_st),
      .quo    (jbin)
   );

   rdh_sdiv #(.NW(ROOT_OUT_W), .DW(21), .QW(QR)) u_rdiv (
      .clock  (clock),
      .reset  (reset),
      .start  (rdiv_start),
      .num    (root),
      .den    (k_ff),
      .status (rdiv_st),
      .quo    (ibin)
   );

   // ----------------------------------------------------------- bin check
   always_comb begin
      nr = (BIN_CNT_W'(nrb_ff) < BIN_CNT_W'(MAX_RADIAL_BINS)) ?
           BIN_CNT_W'(nrb_ff) : BIN_CNT_W'(MAX_RADIAL_BINS);
      nd = (BIN_CNT_W'(ndb_ff) < BIN_CNT_W'(MAX_DENSITY_BINS)) ?
           BIN_CNT_W'(ndb_ff) : BIN_CNT_W'(MAX_DENSITY_BINS);
      hit = !dens_bad_ff && !dden_st.ovf && !rdiv_st.ovf && (k_ff != '0) &&
            (BIN_CNT_W'(ibin) < nr) && (BIN_CNT_W'(jbin) < nd);
      in_range = (32'(rr_ff) < 32'(MAX_RADIAL_BINS)) &&
                 (32'(rd_ff) < 32'(MAX_DENSITY_BINS));
      if (type_ff == REQ_READ) begin
         addr_in = AW'(32'(rr_ff) * 32'(MAX_DENSITY_BINS) + 32'(rd_ff));
      end else begin
         addr_in = AW'(32'(ibin) * 32'(MAX_DENSITY_BINS) + 32'(jbin));
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOOK) begin
         addr_ff     <= addr_in;
         hit_ff      <= (type_ff == REQ_ACCUM) && hit;
         in_range_ff <= (type_ff == REQ_READ) && in_range;
         if (type_ff == REQ_READ) begin
            rbin_ff <= rr_ff;
            dbin_ff <= rd_ff;
         end else if (hit) begin
            rbin_ff <= 6'(ibin);
            dbin_ff <= 6'(jbin);
         end else begin
            rbin_ff <= '0;
            dbin_ff <= '0;
         end
      end
   end

   // --------------------------------------------------------------- memory
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         hist[clr_ff] <= '0;
      end else if ((state_ff == S_FIN) && out_free) begin
         if (hit_ff && (rdata_ff != 32'hFFFF_FFFF)) begin
            hist[addr_ff] <= rdata_ff + 1'b1;
         end else if (in_range_ff) begin
            hist[addr_ff] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOOK) begin
         rdata_ff <= hist[addr_in];
      end
   end

   // --------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if ((state_ff == S_FIN) && out_free) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_FIN) && out_free) begin
         rsp_tdata_ff <= {3'b000, (in_range_ff ? rdata_ff : 32'h0),
                          dbin_ff, rbin_ff, hit_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ----------------------------------------------------------- assertions
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("word accepted during clearing pass");

   a_counted_zero_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[44:13] == 32'h0))
      else $error("accumulate result carries a nonzero count");

   a_units_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (!root_busy && !dden_st.busy && !rdiv_st.busy))
      else $error("word accepted while a serial unit is busy");

   a_fin_from_look: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FIN) && !$past(state_ff == S_FIN)) |-> $past(state_ff == S_LOOK))
      else $error("result stage entered without a memory lookup");

endmodule
